@@ rtl/psmd_pkg.sv @@
// Shared types and constants for the PID sign-magnitude drive core.
// Used by every module in rtl/; has no dependencies of its own.
package psmd_pkg;

  // Sample and field widths.
  localparam int SAMPLE_W  = 8;
  localparam int GAIN_W    = 16;
  localparam int ERR_W     = 9;
  localparam int DER_W     = 10;
  localparam int INTEG_W   = 16;
  localparam int CTRL_W    = 11;
  localparam int DUTY_W    = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Sum of three samples and the reciprocal-of-three multiplier.
  // floor(x * 683 / 2048) equals floor(x / 3) for every x below 2048.
  localparam int SUM3_W      = 10;
  localparam int RECIP3_W    = 10;
  localparam int RECIP3_SH   = 11;
  localparam logic [RECIP3_W-1:0] RECIP3 = 10'd683;

  // Control clamp limit.
  localparam logic signed [CTRL_W-1:0] CTRL_MAX = 11'sd1023;
  localparam logic signed [CTRL_W-1:0] CTRL_MIN = -11'sd1023;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF     = 3'd4;

  // Register reset values.
  localparam logic [SAMPLE_W-1:0] SETPOINT_RST   = 8'd80;
  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST  = 16'd2714;
  localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST = 16'd0;
  localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST = 16'd486;
  localparam logic [SAMPLE_W-1:0] CUTOFF_RST     = 8'd100;

  // Gain set seen by the back end.
  typedef struct packed {
    logic [GAIN_W-1:0] prop;
    logic [GAIN_W-1:0] integ;
    logic [GAIN_W-1:0] deriv;
  } gains_t;

  // One classified step travelling from the front end to the back end.
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [DER_W-1:0]   der;
    logic signed [INTEG_W-1:0] integ;
    logic                      cut;
  } step_t;

endpackage

@@ rtl/psmd_front.sv @@
// Front end: accepts sample words, averages them and forms error terms.
// Holds the previous error and integral state. Depends on psmd_pkg.
module psmd_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_valid,
  output logic                              s_ready,
  input  logic [3*psmd_pkg::SAMPLE_W-1:0]   s_data,
  input  logic [psmd_pkg::SAMPLE_W-1:0]     setpoint,
  input  logic [psmd_pkg::SAMPLE_W-1:0]     cutoff_level,
  output logic                              push,
  output psmd_pkg::step_t                   push_step,
  input  logic                              q_full
);

  logic                              avg_valid;
  logic [psmd_pkg::SAMPLE_W-1:0]     avg;
  logic [psmd_pkg::SUM3_W-1:0]       sum3;
  logic [psmd_pkg::SUM3_W+psmd_pkg::RECIP3_W-1:0] avg_prod;
  logic signed [psmd_pkg::ERR_W-1:0]   previous_error;
  logic signed [psmd_pkg::INTEG_W-1:0] error_sum;
  logic signed [psmd_pkg::ERR_W-1:0]   err;
  logic signed [psmd_pkg::INTEG_W:0]   sum_wide;
  logic signed [psmd_pkg::INTEG_W-1:0] error_sum_next;

  // Three-sample sum and divide by three through a reciprocal multiply.
  assign sum3 = psmd_pkg::SUM3_W'(s_data[7:0]) + psmd_pkg::SUM3_W'(s_data[15:8])
              + psmd_pkg::SUM3_W'(s_data[23:16]);
  assign avg_prod = sum3 * psmd_pkg::RECIP3;

  // The average stage takes a new word when empty or when it hands its word on.
  assign push    = avg_valid && !q_full;
  assign s_ready = !avg_valid || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_valid <= 1'b0;
    end else if (s_ready) begin
      avg_valid <= s_valid;
    end
    if (s_ready && s_valid) begin
      avg <= avg_prod[psmd_pkg::RECIP3_SH +: psmd_pkg::SAMPLE_W];
    end
  end

  // Error, derivative and saturating integral.
  assign err      = $signed({1'b0, setpoint}) - $signed({1'b0, avg});
  assign sum_wide = (psmd_pkg::INTEG_W+1)'(error_sum) + (psmd_pkg::INTEG_W+1)'(err);

  always_comb begin
    if (sum_wide[psmd_pkg::INTEG_W] != sum_wide[psmd_pkg::INTEG_W-1]) begin
      error_sum_next = sum_wide[psmd_pkg::INTEG_W] ?
        {1'b1, {(psmd_pkg::INTEG_W-1){1'b0}}} : {1'b0, {(psmd_pkg::INTEG_W-1){1'b1}}};
    end else begin
      error_sum_next = sum_wide[psmd_pkg::INTEG_W-1:0];
    end
  end

  always_comb begin
    push_step.err   = err;
    push_step.der   = psmd_pkg::DER_W'(err) - psmd_pkg::DER_W'(previous_error);
    push_step.integ = error_sum_next;
    push_step.cut   = (avg >= cutoff_level);
  end

  // Controller state advances once per step as it enters the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_sum      <= '0;
    end else if (push) begin
      previous_error <= err;
      error_sum      <= error_sum_next;
    end
  end

endmodule

@@ rtl/psmd_queue.sv @@
// Two-entry queue of classified steps between front end and back end.
// Depends on psmd_pkg for the step type.
module psmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  psmd_pkg::step_t push_step,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output psmd_pkg::step_t q_step
);

  psmd_pkg::step_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_step  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_step;
    end
  end

endmodule

@@ rtl/psmd_back.sv @@
// Back end: gain multiplies, accumulation, scaling, clamp and drive split.
// Three-stage elastic pipeline ending in the output register. Depends on psmd_pkg.
module psmd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  psmd_pkg::gains_t              gains,
  input  logic                          q_valid,
  input  psmd_pkg::step_t               q_step,
  output logic                          pop,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic [psmd_pkg::DUTY_W-1:0]   duty,
  output logic                          reverse,
  output logic signed [psmd_pkg::CTRL_W-1:0] control_value,
  output logic                          cutoff_hit
);

  localparam int PP_W  = psmd_pkg::GAIN_W + psmd_pkg::ERR_W + 1;
  localparam int IP_W  = psmd_pkg::GAIN_W + psmd_pkg::INTEG_W + 1;
  localparam int DP_W  = psmd_pkg::GAIN_W + psmd_pkg::DER_W + 1;
  localparam int ACC_W = IP_W + 1;
  localparam int Q_W   = ACC_W - 8;

  logic                    mul_valid;
  logic signed [PP_W-1:0]  prop_term;
  logic signed [IP_W-1:0]  integ_term;
  logic signed [DP_W-1:0]  deriv_term;
  logic                    mul_cut;
  logic                    acc_valid;
  logic signed [ACC_W-1:0] acc;
  logic                    acc_cut;
  logic                    out_adv;
  logic                    acc_ld;
  logic                    mul_ld;
  logic signed [ACC_W-1:0] acc_biased;
  logic signed [Q_W-1:0]   quot;
  logic signed [psmd_pkg::CTRL_W-1:0] ctrl;

  // Stall chain: each stage loads when empty or when its successor loads.
  assign out_adv = !m_valid || m_ready;
  assign acc_ld  = !acc_valid || out_adv;
  assign mul_ld  = !mul_valid || acc_ld;
  assign pop     = mul_ld && q_valid;

  // Stage 1: the three gain products.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_ld) begin
      mul_valid <= q_valid;
    end
    if (pop) begin
      prop_term  <= $signed({1'b0, gains.prop}) * q_step.err;
      integ_term <= $signed({1'b0, gains.integ}) * q_step.integ;
      deriv_term <= $signed({1'b0, gains.deriv}) * q_step.der;
      mul_cut    <= q_step.cut;
    end
  end

  // Stage 2: accumulate the products.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (acc_ld) begin
      acc_valid <= mul_valid;
    end
    if (acc_ld && mul_valid) begin
      acc     <= ACC_W'(prop_term) + ACC_W'(integ_term) + ACC_W'(deriv_term);
      acc_cut <= mul_cut;
    end
  end

  // Divide by 256 rounding toward zero, then clamp.
  assign acc_biased = acc[ACC_W-1] ? acc + ACC_W'(255) : acc;
  assign quot       = acc_biased[ACC_W-1:8];

  always_comb begin
    if (quot > Q_W'(psmd_pkg::CTRL_MAX)) begin
      ctrl = psmd_pkg::CTRL_MAX;
    end else if (quot < Q_W'(psmd_pkg::CTRL_MIN)) begin
      ctrl = psmd_pkg::CTRL_MIN;
    end else begin
      ctrl = quot[psmd_pkg::CTRL_W-1:0];
    end
  end

  // Stage 3: sign-magnitude split into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (out_adv) begin
      m_valid <= acc_valid;
    end
    if (out_adv && acc_valid) begin
      control_value <= ctrl;
      cutoff_hit    <= acc_cut;
      if (acc_cut) begin
        reverse <= 1'b1;
        duty    <= '0;
      end else if (ctrl[psmd_pkg::CTRL_W-1]) begin
        reverse <= 1'b1;
        duty    <= psmd_pkg::DUTY_W'(-ctrl);
      end else begin
        reverse <= 1'b0;
        duty    <= ctrl[psmd_pkg::DUTY_W-1:0];
      end
    end
  end

endmodule

@@ rtl/pid_sign_magnitude_drive_core.sv @@
// Top level of the PID sign-magnitude drive core: configuration registers,
// front end, step queue and back end. Depends on psmd_pkg and the psmd_* modules.
//
// Each input word carries three field samples; the core averages them, runs a
// PID update with saturating integral and Q8.8 gains, and returns one word per
// input with the clamped control, its sign-magnitude drive and the cutoff flag.
// One word is accepted every clock cycle when the output side keeps up; a word
// passes the averaging register, a queue entry, then the multiply, accumulate
// and scale/clamp stages of the back end. A two-entry queue decouples the front
// end, which owns the controller state, from the back end pipeline, so either
// side may stall alone. The user is to write configuration through cfg_wr_en/
// cfg_index/cfg_data only while idle; the block itself does not enforce this.
module pid_sign_magnitude_drive_core (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write port.
  input  logic                               cfg_wr_en,
  input  logic [psmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psmd_pkg::CFG_DAT_W-1:0]     cfg_data,
  // Sample stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] sample_first, [15:8] sample_second, [23:16] sample_third
  input  logic [23:0]                        s_axis_tdata,
  // Drive stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [9:0] duty, [10] reverse, [21:11] control_value, [22] cutoff_hit, [23] zero
  output logic [23:0]                        m_axis_tdata
);

  logic [psmd_pkg::SAMPLE_W-1:0] setpoint;
  logic [psmd_pkg::SAMPLE_W-1:0] cutoff_level;
  psmd_pkg::gains_t              gains;
  logic                          push;
  psmd_pkg::step_t               push_step;
  logic                          q_full;
  logic                          pop;
  logic                          q_valid;
  psmd_pkg::step_t               q_step;
  logic [psmd_pkg::DUTY_W-1:0]   duty;
  logic                          reverse;
  logic signed [psmd_pkg::CTRL_W-1:0] control_value;
  logic                          cutoff_hit;

  // Configuration registers; writes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint     <= psmd_pkg::SETPOINT_RST;
      gains.prop   <= psmd_pkg::PROP_GAIN_RST;
      gains.integ  <= psmd_pkg::INTEG_GAIN_RST;
      gains.deriv  <= psmd_pkg::DERIV_GAIN_RST;
      cutoff_level <= psmd_pkg::CUTOFF_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        psmd_pkg::REG_SETPOINT:   setpoint     <= cfg_data[psmd_pkg::SAMPLE_W-1:0];
        psmd_pkg::REG_PROP_GAIN:  gains.prop   <= cfg_data;
        psmd_pkg::REG_INTEG_GAIN: gains.integ  <= cfg_data;
        psmd_pkg::REG_DERIV_GAIN: gains.deriv  <= cfg_data;
        psmd_pkg::REG_CUTOFF:     cutoff_level <= cfg_data[psmd_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  psmd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_valid      (s_axis_tvalid),
    .s_ready      (s_axis_tready),
    .s_data       (s_axis_tdata),
    .setpoint     (setpoint),
    .cutoff_level (cutoff_level),
    .push         (push),
    .push_step    (push_step),
    .q_full       (q_full)
  );

  psmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_step (push_step),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_step    (q_step)
  );

  psmd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .gains         (gains),
    .q_valid       (q_valid),
    .q_step        (q_step),
    .pop           (pop),
    .m_valid       (m_axis_tvalid),
    .m_ready       (m_axis_tready),
    .duty          (duty),
    .reverse       (reverse),
    .control_value (control_value),
    .cutoff_hit    (cutoff_hit)
  );

  // Output word packing.
  assign m_axis_tdata = {1'b0, cutoff_hit, control_value, reverse, duty};

endmodule

@@ tb/psmd_drive_checker.sv @@
// Checker for the PID sign-magnitude drive core: tracks register writes,
// predicts one drive word per sample word and compares it on the drive stream.
// Depends on psmd_pkg for widths and register indexes.
module psmd_drive_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [psmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psmd_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // [7:0] sample_first, [15:8] sample_second, [23:16] sample_third
  input  logic [23:0]                    s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [9:0] duty, [10] reverse, [21:11] control_value, [22] cutoff_hit, [23] zero
  input  logic [23:0]                    m_axis_tdata,
  output int                             mismatch_count,
  output int                             words_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CTRL_LIM   = 1023;

  // One predicted drive word.
  typedef struct packed {
    logic                               cut;
    logic signed [psmd_pkg::CTRL_W-1:0] ctrl;
    logic                               rev;
    logic [psmd_pkg::DUTY_W-1:0]        duty;
  } drive_t;

  // Register copies as the block should hold them.
  logic [psmd_pkg::SAMPLE_W-1:0] field_target;
  logic [psmd_pkg::SAMPLE_W-1:0] cutoff_lvl;
  logic [psmd_pkg::GAIN_W-1:0]   kp;
  logic [psmd_pkg::GAIN_W-1:0]   ki;
  logic [psmd_pkg::GAIN_W-1:0]   kd;

  // Controller state.
  logic signed [psmd_pkg::ERR_W-1:0]   last_err;
  logic signed [psmd_pkg::INTEG_W-1:0] err_integral;

  drive_t drive_queue[$];

  // Runs one control step and advances the controller state.
  function automatic drive_t predict_drive(input logic [23:0] word);
    int     avg;
    int     err;
    int     der;
    int     isum;
    longint acc;
    longint ctrl;
    drive_t d;
    avg  = (int'(word[7:0]) + int'(word[15:8]) + int'(word[23:16])) / 3;
    err  = int'(field_target) - avg;
    der  = err - int'(last_err);
    isum = int'(err_integral) + err;
    if (isum > 32767) isum = 32767;
    if (isum < -32768) isum = -32768;
    last_err     = psmd_pkg::ERR_W'(err);
    err_integral = psmd_pkg::INTEG_W'(isum);
    // Signed division truncates toward zero, as the scaling requires.
    acc  = longint'(int'(kp)) * err + longint'(int'(ki)) * isum
         + longint'(int'(kd)) * der;
    ctrl = acc / 256;
    if (ctrl > CTRL_LIM) ctrl = CTRL_LIM;
    if (ctrl < -CTRL_LIM) ctrl = -CTRL_LIM;
    d.ctrl = psmd_pkg::CTRL_W'(ctrl);
    d.cut  = (avg >= int'(cutoff_lvl));
    if (d.cut) begin
      d.rev  = 1'b1;
      d.duty = '0;
    end else if (ctrl >= 0) begin
      d.rev  = 1'b0;
      d.duty = psmd_pkg::DUTY_W'(ctrl);
    end else begin
      d.rev  = 1'b1;
      d.duty = psmd_pkg::DUTY_W'(-ctrl);
    end
    return d;
  endfunction

  function automatic void report(input string field, input int want, input int got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatch_count++;
  endfunction

  // Follow the configuration port, predict on every sample word and check every drive word.
  always @(posedge clk) begin
    drive_t want;
    drive_t got;
    if (rst) begin
      field_target   = psmd_pkg::SETPOINT_RST;
      cutoff_lvl     = psmd_pkg::CUTOFF_RST;
      kp             = psmd_pkg::PROP_GAIN_RST;
      ki             = psmd_pkg::INTEG_GAIN_RST;
      kd             = psmd_pkg::DERIV_GAIN_RST;
      last_err       = '0;
      err_integral   = '0;
      mismatch_count = 0;
      drive_queue.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          psmd_pkg::REG_SETPOINT:   field_target = cfg_data[psmd_pkg::SAMPLE_W-1:0];
          psmd_pkg::REG_PROP_GAIN:  kp = cfg_data;
          psmd_pkg::REG_INTEG_GAIN: ki = cfg_data;
          psmd_pkg::REG_DERIV_GAIN: kd = cfg_data;
          psmd_pkg::REG_CUTOFF:     cutoff_lvl = cfg_data[psmd_pkg::SAMPLE_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        drive_queue.push_back(predict_drive(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = drive_t'(m_axis_tdata[22:0]);
        if (drive_queue.size() == 0) begin
          $display("%0t ns: drive word with none expected, expected nothing, got %h",
                   $time, m_axis_tdata);
          mismatch_count++;
        end else begin
          want = drive_queue.pop_front();
          if (got.duty !== want.duty) report("duty", want.duty, got.duty);
          if (got.rev !== want.rev) report("reverse", want.rev, got.rev);
          if (got.ctrl !== want.ctrl) report("control_value", want.ctrl, got.ctrl);
          if (got.cut !== want.cut) report("cutoff_hit", want.cut, got.cut);
          if (m_axis_tdata[23] !== 1'b0) report("padding bit", 0, m_axis_tdata[23]);
        end
      end
    end
    words_in_flight = drive_queue.size();
  end

endmodule

@@ tb/tb_pid_sign_magnitude_drive_core.sv @@
// Testbench top for the PID sign-magnitude drive core: clock, reset, register
// programming, sample stimulus with random idling, and the verdict.
// Depends on psmd_pkg, the core RTL and psmd_drive_checker.
module tb_pid_sign_magnitude_drive_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1300;
  localparam int PIPE_LATENCY = 5;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 4000;

  typedef enum {SPREAD, NEAR_TARGET, LOW_FIELD, HIGH_FIELD} field_mode_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_wr_en;
  logic [psmd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [psmd_pkg::CFG_DAT_W-1:0] cfg_data;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [23:0]                    s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [23:0]                    m_axis_tdata;

  int mismatch_count;
  int words_in_flight;
  int stall_cycles = 0;

  // Stimulus settings; rx_idle_en and long_hold are also read by the receiver process.
  bit tx_idle_en  = 1'b0;
  bit rx_idle_en  = 1'b0;
  bit long_hold   = 1'b0;
  logic [psmd_pkg::SAMPLE_W-1:0] cur_target = psmd_pkg::SETPOINT_RST;

  pid_sign_magnitude_drive_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  psmd_drive_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatch_count  (mismatch_count),
    .words_in_flight (words_in_flight)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on cycles with no word moving on either stream.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("[pid_sign_magnitude_drive_core] ERROR");
      $finish;
    end
  end

  // Drive stream receiver: random back-pressure bursts and one long hold on request.
  initial begin
    bit held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_hold && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [psmd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psmd_pkg::CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // 8-bit registers get junk in the upper byte, which the block must drop.
  task automatic write_byte_reg(input logic [psmd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [7:0] val);
    write_reg(idx, {8'($urandom_range(0, 255)), val});
    if (idx == psmd_pkg::REG_SETPOINT) cur_target = val;
  endtask

  // Offers one sample word, with an optional idle burst ahead of it.
  task automatic send_samples(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 24'($urandom);
      repeat ($urandom_range(1, 11) - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, b, a};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stops offering and waits until every drive word has come back.
  task automatic drain;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (words_in_flight == 0);
  endtask

  function automatic logic [psmd_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return psmd_pkg::GAIN_W'($urandom_range(0, 65535));
      default: return psmd_pkg::GAIN_W'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [7:0] pick_byte(input int lo);
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(lo, 255));
    endcase
  endfunction

  function automatic logic [7:0] make_sample(input field_mode_t mode);
    int v;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    case (mode)
      NEAR_TARGET: begin
        v = int'(cur_target) + $urandom_range(0, 24) - 12;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
      end
      LOW_FIELD:  return 8'($urandom_range(0, 24));
      HIGH_FIELD: return 8'($urandom_range(230, 255));
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // New register set, including writes to the unused indexes that must be ignored.
  task automatic program_random_settings;
    write_byte_reg(psmd_pkg::REG_SETPOINT, pick_byte(0));
    write_reg(psmd_pkg::REG_PROP_GAIN, pick_gain());
    write_reg(psmd_pkg::REG_INTEG_GAIN, pick_gain());
    write_reg(psmd_pkg::REG_DERIV_GAIN, pick_gain());
    write_byte_reg(psmd_pkg::REG_CUTOFF, pick_byte(100));
    for (int k = int'(psmd_pkg::REG_CUTOFF) + 1; k < (1 << psmd_pkg::CFG_IDX_W); k++)
      write_reg(psmd_pkg::CFG_IDX_W'(k), psmd_pkg::CFG_DAT_W'($urandom_range(0, 65535)));
  endtask

  initial begin
    int          total;
    int          phase;
    int          len;
    bit          tail;
    field_mode_t mode;

    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: truncating average, cutoff edges and large swings.
    send_samples(8'd0, 8'd0, 8'd0);
    send_samples(8'd255, 8'd255, 8'd255);
    send_samples(8'd100, 8'd100, 8'd100);
    send_samples(8'd99, 8'd100, 8'd100);
    send_samples(8'd1, 8'd1, 8'd0);
    send_samples(8'd2, 8'd2, 8'd1);
    send_samples(8'd255, 8'd0, 8'd0);
    send_samples(8'd0, 8'd255, 8'd0);
    send_samples(8'd0, 8'd0, 8'd255);
    send_samples(8'd80, 8'd80, 8'd80);
    send_samples(8'd81, 8'd80, 8'd80);
    send_samples(8'd0, 8'd0, 8'd0);

    // Full-scale gains and target: positive clamp and the top cutoff level.
    drain();
    write_byte_reg(psmd_pkg::REG_SETPOINT, 8'd255);
    write_reg(psmd_pkg::REG_PROP_GAIN, '1);
    write_reg(psmd_pkg::REG_INTEG_GAIN, '1);
    write_reg(psmd_pkg::REG_DERIV_GAIN, '1);
    write_byte_reg(psmd_pkg::REG_CUTOFF, 8'd255);
    send_samples(8'd0, 8'd0, 8'd0);
    send_samples(8'd0, 8'd0, 8'd0);
    send_samples(8'd254, 8'd255, 8'd255);
    send_samples(8'd255, 8'd255, 8'd255);

    // Zero target: negative clamp, then a zero cutoff that forces every step off.
    drain();
    write_byte_reg(psmd_pkg::REG_SETPOINT, 8'd0);
    send_samples(8'd200, 8'd200, 8'd200);
    send_samples(8'd254, 8'd254, 8'd254);
    drain();
    write_byte_reg(psmd_pkg::REG_CUTOFF, 8'd0);
    write_reg(psmd_pkg::REG_PROP_GAIN, '0);
    send_samples(8'd0, 8'd0, 8'd0);
    send_samples(8'd255, 8'd255, 8'd255);

    // Random phases. The first two drive the integral into both saturation limits.
    total = 0;
    phase = 0;
    while (total < RANDOM_WORDS) begin
      drain();
      program_random_settings();
      if (phase == 0) begin
        write_byte_reg(psmd_pkg::REG_SETPOINT, 8'd255);
        write_byte_reg(psmd_pkg::REG_CUTOFF, 8'd255);
        mode = LOW_FIELD;
        len  = 150;
      end else if (phase == 1) begin
        write_byte_reg(psmd_pkg::REG_SETPOINT, 8'd0);
        write_byte_reg(psmd_pkg::REG_CUTOFF, 8'd255);
        mode = HIGH_FIELD;
        len  = 300;
      end else begin
        mode = field_mode_t'($urandom_range(0, 3));
        len  = $urandom_range(40, 140);
      end
      tail       = (total > RANDOM_WORDS - 200);
      tx_idle_en = !tail && ($urandom_range(0, 3) != 0);
      rx_idle_en = !tail && ($urandom_range(0, 3) != 0);
      if (phase == 2) long_hold = 1'b1;
      repeat (len) send_samples(make_sample(mode), make_sample(mode), make_sample(mode));
      total += len;
      phase++;
    end

    drain();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (mismatch_count == 0 && words_in_flight == 0)
      $display("[pid_sign_magnitude_drive_core] OK");
    else
      $display("[pid_sign_magnitude_drive_core] ERROR");
    $finish;
  end

endmodule
